// File: src/cdq_pkg.sv
package cdq_pkg;

	localparam int DepthDefault = 8;

	localparam int ItemW = 8;
	localparam int OccW  = 4;

	typedef enum logic [1:0] {
		REQ_INS_FRONT = 2'd0,
		REQ_INS_REAR  = 2'd1,
		REQ_REM_FRONT = 2'd2,
		REQ_REM_REAR  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} slot_cmd_t;

endpackage

// File: src/cdq_mem.sv
module cdq_mem #(
	parameter int DEPTH = cdq_pkg::DepthDefault
) (
	input  logic                        clk,
	input  cdq_pkg::slot_cmd_t          cmd,
	input  logic [$clog2(DEPTH)-1:0]    addr,
	input  logic [cdq_pkg::ItemW-1:0]   wdata,
	output logic [cdq_pkg::ItemW-1:0]   rdata
);
	import cdq_pkg::*;

	logic [ItemW-1:0] slots [DEPTH];
	logic [ItemW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			slots[addr] <= wdata;
		end
		// hold the last read word until the next read
		if (cmd.rd) begin
			rdata_q <= slots[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/cdq_ctrl.sv
module cdq_ctrl #(
	parameter int DEPTH = cdq_pkg::DepthDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [1:0]                  req_type,
	output cdq_pkg::slot_cmd_t          cmd,
	output logic [$clog2(DEPTH)-1:0]    addr,
	output cdq_pkg::status_t            status_nxt,
	output logic [cdq_pkg::OccW-1:0]    occ_nxt
);
	import cdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          full, empty;
	slot_cmd_t     cmd_raw;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign tail_inc = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? AW'(DEPTH - 1) : tail_q - 1'b1;

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		cnt_d      = cnt_q;
		cmd_raw    = '0;
		addr       = head_q;
		status_nxt = ST_OK;
		case (req_t'(req_type))
			REQ_INS_FRONT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					cmd_raw.wr = 1'b1;
					addr       = head_dec;
					head_d     = head_dec;
					cnt_d      = cnt_q + 1'b1;
				end
			end
			REQ_INS_REAR: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					cmd_raw.wr = 1'b1;
					addr       = tail_q;
					tail_d     = tail_inc;
					cnt_d      = cnt_q + 1'b1;
				end
			end
			REQ_REM_FRONT: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					cmd_raw.rd = 1'b1;
					addr       = head_q;
					head_d     = head_inc;
					cnt_d      = cnt_q - 1'b1;
				end
			end
			REQ_REM_REAR: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					cmd_raw.rd = 1'b1;
					addr       = tail_dec;
					tail_d     = tail_dec;
					cnt_d      = cnt_q - 1'b1;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	assign cmd.wr  = cmd_raw.wr & accept;
	assign cmd.rd  = cmd_raw.rd & accept;
	assign occ_nxt = OccW'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// File: src/circular_deque.sv
// Circular double-ended byte queue holding DEPTH entries. Each word on the
// input channel inserts or removes at the front or rear and yields exactly one
// result word carrying the removed byte (zero for inserts and errors), a status
// (full on insert, empty on remove) and the occupancy after the request; a
// failed request changes nothing. Results come in the cycle after acceptance,
// and a new request is taken every cycle as long as the pending result is
// taken, since each request makes a single access to the one-port slot memory
// and the pointer update completes in the cycle of acceptance. The slot memory
// needs no clearing: only entries written by an earlier insert are ever read.
module circular_deque #(
	parameter int DEPTH = cdq_pkg::DepthDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [cdq_pkg::ItemW-1:0]   item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cdq_pkg::ItemW-1:0]   data,
	output logic [1:0]                  status,
	output logic [cdq_pkg::OccW-1:0]    occupancy
);
	import cdq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic              accept;
	slot_cmd_t         cmd;
	logic [AW-1:0]     addr;
	status_t           status_nxt;
	logic [OccW-1:0]   occ_nxt;
	logic [ItemW-1:0]  rdata;

	logic              valid_s1;
	logic              rd_s1;
	status_t           status_s1;
	logic [OccW-1:0]   occ_s1;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_type),
		.cmd        (cmd),
		.addr       (addr),
		.status_nxt (status_nxt),
		.occ_nxt    (occ_nxt)
	);

	cdq_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.cmd   (cmd),
		.addr  (addr),
		.wdata (item),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// advance the result stage only when a new word enters
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= cmd.rd;
			status_s1 <= status_nxt;
			occ_s1    <= occ_nxt;
		end
	end

	assign out_valid = valid_s1;
	assign data      = rd_s1 ? rdata : '0;
	assign status    = status_s1;
	assign occupancy = occ_s1;

endmodule

// File: verif/tb_circular_deque.sv
module tb_circular_deque;
	import cdq_pkg::*;

	localparam int DEPTH      = DepthDefault;
	localparam int RandWords  = 1900;
	localparam int CycleLimit = 400000;
	localparam int HoldCycles = 300;

	typedef struct packed {
		logic [ItemW-1:0] data;
		status_t          st;
		logic [OccW-1:0]  occ;
	} deque_res_t;

	typedef struct {
		req_t             req;
		logic [ItemW-1:0] val;
		bit               typed;
		deque_res_t       res;
	} dir_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	logic [1:0]       req_type  = 2'd0;
	logic [ItemW-1:0] item      = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [ItemW-1:0] data;
	logic [1:0]       status;
	logic [OccW-1:0]  occupancy;

	circular_deque #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.item      (item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (data),
		.status    (status),
		.occupancy (occupancy)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow deque
	logic [ItemW-1:0] shadow [DEPTH];
	int unsigned      front_at = 0;
	int unsigned      back_at  = 0;
	int unsigned      held     = 0;

	deque_res_t owed_results [$];

	int unsigned n_words   = 0;
	int unsigned n_results = 0;
	int unsigned n_errors  = 0;
	int unsigned n_full    = 0;
	int unsigned n_empty   = 0;
	int unsigned n_removed = 0;
	int unsigned cycles    = 0;
	bit          rx_held   = 1'b0;

	// Each row checks against the typed result when typed is set, else the shadow deque.
	dir_row_t dir_rows [25] = '{
		'{REQ_REM_FRONT, 8'h00, 1'b1, '{8'h00, ST_EMPTY, 4'd0}},
		'{REQ_REM_REAR,  8'hFF, 1'b1, '{8'h00, ST_EMPTY, 4'd0}},
		'{REQ_INS_FRONT, 8'h00, 1'b1, '{8'h00, ST_OK,    4'd1}},
		'{REQ_INS_REAR,  8'hFF, 1'b1, '{8'h00, ST_OK,    4'd2}},
		'{REQ_REM_FRONT, 8'hFF, 1'b1, '{8'h00, ST_OK,    4'd1}},
		'{REQ_REM_REAR,  8'h00, 1'b1, '{8'hFF, ST_OK,    4'd0}},
		'{REQ_INS_REAR,  8'hA5, 1'b1, '{8'h00, ST_OK,    4'd1}},
		'{REQ_INS_FRONT, 8'h5A, 1'b1, '{8'h00, ST_OK,    4'd2}},
		'{REQ_INS_REAR,  8'h01, 1'b1, '{8'h00, ST_OK,    4'd3}},
		'{REQ_INS_FRONT, 8'h80, 1'b1, '{8'h00, ST_OK,    4'd4}},
		'{REQ_INS_REAR,  8'h7F, 1'b1, '{8'h00, ST_OK,    4'd5}},
		'{REQ_INS_FRONT, 8'hFE, 1'b1, '{8'h00, ST_OK,    4'd6}},
		'{REQ_INS_REAR,  8'h55, 1'b1, '{8'h00, ST_OK,    4'd7}},
		'{REQ_INS_FRONT, 8'hAA, 1'b1, '{8'h00, ST_OK,    4'd8}},
		'{REQ_INS_REAR,  8'h33, 1'b1, '{8'h00, ST_FULL,  4'd8}},
		'{REQ_INS_FRONT, 8'hCC, 1'b1, '{8'h00, ST_FULL,  4'd8}},
		'{REQ_REM_FRONT, 8'h00, 1'b0, '{8'h00, ST_OK,    4'd0}},
		'{REQ_REM_REAR,  8'h00, 1'b0, '{8'h00, ST_OK,    4'd0}},
		'{REQ_REM_FRONT, 8'h00, 1'b0, '{8'h00, ST_OK,    4'd0}},
		'{REQ_REM_REAR,  8'h00, 1'b0, '{8'h00, ST_OK,    4'd0}},
		'{REQ_REM_REAR,  8'h00, 1'b0, '{8'h00, ST_OK,    4'd0}},
		'{REQ_REM_REAR,  8'h00, 1'b0, '{8'h00, ST_OK,    4'd0}},
		'{REQ_REM_FRONT, 8'h00, 1'b0, '{8'h00, ST_OK,    4'd0}},
		'{REQ_REM_FRONT, 8'h00, 1'b0, '{8'h00, ST_OK,    4'd0}},
		'{REQ_REM_FRONT, 8'h00, 1'b1, '{8'h00, ST_EMPTY, 4'd0}}
	};

	function automatic deque_res_t apply_request(req_t r, logic [ItemW-1:0] v);
		deque_res_t res;
		res = '{data: '0, st: ST_OK, occ: '0};
		if (r == REQ_INS_FRONT || r == REQ_INS_REAR) begin
			if (held >= DEPTH) begin
				res.st = ST_FULL;
				n_full++;
			end else if (r == REQ_INS_FRONT) begin
				front_at = (front_at + DEPTH - 1) % DEPTH;
				shadow[front_at] = v;
				held++;
			end else begin
				shadow[back_at] = v;
				back_at = (back_at + 1) % DEPTH;
				held++;
			end
		end else begin
			if (held == 0) begin
				res.st = ST_EMPTY;
				n_empty++;
			end else if (r == REQ_REM_FRONT) begin
				res.data = shadow[front_at];
				front_at = (front_at + 1) % DEPTH;
				held--;
				n_removed++;
			end else begin
				back_at = (back_at + DEPTH - 1) % DEPTH;
				res.data = shadow[back_at];
				held--;
				n_removed++;
			end
		end
		res.occ = OccW'(held);
		return res;
	endfunction

	bit tx_quiet = 1'b0;

	task automatic send_word(input req_t r, input logic [ItemW-1:0] v, input bit typed,
			input deque_res_t typed_res);
		int unsigned gap;
		deque_res_t  res;
		if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r;
		item     <= v;
		do @(posedge clk); while (!in_ready);
		res = apply_request(r, v);
		owed_results.push_back(typed ? typed_res : res);
		n_words++;
	endtask

	initial begin
		int unsigned ins_pct;
		bit          is_rem;
		req_t        r;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_word(dir_rows[i].req, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
		ins_pct = 50;
		for (int i = 0; i < RandWords; i++) begin
			// Swing the insert share so the deque runs full and empty many times
			if (i % 60 == 0) begin
				case ($urandom_range(0, 4))
					0: ins_pct = 5;
					1: ins_pct = 30;
					2: ins_pct = 50;
					3: ins_pct = 70;
					default: ins_pct = 95;
				endcase
			end
			is_rem = $urandom_range(0, 99) >= ins_pct;
			r = req_t'({is_rem, 1'($urandom_range(0, 1))});
			send_word(r, ItemW'($urandom_range(0, 255)), 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d request words (%0d directed), checked %0d results.",
			n_words, $size(dir_rows), n_results);
		$display("Saw %0d full rejects, %0d empty rejects and %0d good removals.",
			n_full, n_empty, n_removed);
		if (n_errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		int unsigned stall;
		bit          rx_quiet;
		deque_res_t  got;
		deque_res_t  want;
		rx_quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
			stall = rx_quiet ? 0 : $urandom_range(0, 13);
			// Hold off once for a long stretch so the input side backs up
			if (!rx_held && n_results == 400) begin
				rx_held = 1'b1;
				stall   = HoldCycles;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			n_results++;
			got = '{data: data, st: status_t'(status), occ: occupancy};
			if (owed_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("Unexpected result word: data %02h status %0d occupancy %0d",
						got.data, got.st, got.occ);
			end else begin
				want = owed_results.pop_front();
				if (got.data !== want.data || got.st !== want.st || got.occ !== want.occ) begin
					n_errors++;
					if (n_errors <= 10)
						$display("Mismatch on result %0d: expected %02h/%0d/%0d, got %02h/%0d/%0d",
							n_results, want.data, want.st, want.occ,
							got.data, got.st, got.occ);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycles, owed_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

// File: files.f
src/cdq_pkg.sv
src/cdq_mem.sv
src/cdq_ctrl.sv
src/circular_deque.sv
verif/tb_circular_deque.sv
